/* rtl/core/nfpa_pkg.sv */
package nfpa_pkg;

	// Table geometry
	localparam int MAX_PADS      = 64;
	localparam int LOC_W         = 11;
	localparam int PAD_IDX_W     = $clog2(MAX_PADS);
	localparam int CNT_W         = $clog2(MAX_PADS + 1);

	// Request and result field widths
	localparam int NET_W         = 16;
	localparam int SRC_W         = 10;
	localparam int BATCH_W       = 7;
	localparam logic [BATCH_W-1:0] BATCH_MAX = {BATCH_W{1'b1}};

	// Distance arithmetic: wide enough for either operand plus a sign
	localparam int WIDE_W        = (LOC_W > SRC_W) ? LOC_W : SRC_W;
	localparam int DIFF_W        = WIDE_W + 2;
	localparam int DIST_W        = DIFF_W - 1;

	// Op codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_ASSIGN = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOFREE = 2'd2,
		ST_SKIP   = 2'd3
	} status_t;

	// Best-candidate token that walks down the row of cells
	typedef struct packed {
		logic                 found;
		logic [DIST_W-1:0]    gap;
		logic [PAD_IDX_W-1:0] idx;
	} scan_tok_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                 wr;
		logic                 mark;
		logic                 clr;
		logic [PAD_IDX_W-1:0] sel;
		logic [LOC_W-1:0]     loc;
		logic                 supply;
		logic [NET_W-1:0]     owner;
		logic [SRC_W-1:0]     sx;
		logic [CNT_W-1:0]     pad_count;
	} cell_ctrl_t;

endpackage

/* rtl/core/nfpa_cell.sv */
module nfpa_cell
	import nfpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAD_IDX_W-1:0] cell_idx,
	input  cell_ctrl_t           ctrl,
	input  scan_tok_t            tok_in,
	output scan_tok_t            tok_out
);

	logic [LOC_W-1:0]         loc_q;
	logic                     supply_q;
	logic                     used_q;
	logic [NET_W-1:0]         owner_q;
	scan_tok_t                tok_q;

	logic                     hit;
	logic                     present;
	logic                     eligible;
	logic signed [DIFF_W-1:0] loc_ext;
	logic signed [DIFF_W-1:0] sx_ext;
	logic signed [DIFF_W-1:0] diff;
	logic [DIST_W-1:0]        gap;
	logic                     take;

	assign hit     = (ctrl.sel == cell_idx);
	assign present = ({1'b0, cell_idx} < (PAD_IDX_W + 1)'(ctrl.pad_count));

	// Absolute distance from this pad to the source
	assign loc_ext  = DIFF_W'($signed(loc_q));
	assign sx_ext   = $signed(DIFF_W'(ctrl.sx));
	assign diff     = loc_ext - sx_ext;
	assign gap      = diff[DIFF_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

	// Strictly nearer only: earlier cells win ties
	assign eligible = present && !used_q && !supply_q;
	assign take     = eligible && (!tok_in.found || (gap < tok_in.gap));

	// Pad entry payload
	always_ff @(posedge clk) begin
		if (ctrl.wr && hit) begin
			loc_q    <= ctrl.loc;
			supply_q <= ctrl.supply;
		end
		if (ctrl.mark && hit) begin
			owner_q <= ctrl.owner;
		end
	end

	// Used mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctrl.clr) begin
			used_q <= 1'b0;
		end else if (ctrl.wr && hit) begin
			used_q <= 1'b0;
		end else if (ctrl.mark && hit) begin
			used_q <= 1'b1;
		end
	end

	// Hand the better candidate to the next cell
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q.found <= 1'b1;
			tok_q.gap   <= gap;
			tok_q.idx   <= cell_idx;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/nearest_free_pad_allocator.sv */
// Nearest free pad allocator.
// One request channel: start with op, pad_is_supply, pad_location, net_id,
// has_source, source_x and last_net. A request is taken on a clock edge with
// start high and busy low. Every request yields exactly one result on status,
// pad_index and assigned_total, marked by done for a single cycle.
// Add, clear and no-op requests answer in the cycle after acceptance and do
// not raise busy, so one may be issued every cycle.
// An assign with a source walks a best-candidate token down the row of 64 pad
// cells, one cell per cycle; busy is high until the result appears. The length
// of the cell row sets how long the scan lasts.
// Assigns without a source answer in the cycle after acceptance.
// Reset empties the table, clears all used marks and the batch count.
// The receiver cannot stall: done is a one-cycle strobe and must be taken.
module nearest_free_pad_allocator
	import nfpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           op,
	input  logic                 pad_is_supply,
	input  logic signed [LOC_W-1:0] pad_location,
	input  logic [NET_W-1:0]     net_id,
	input  logic                 has_source,
	input  logic [SRC_W-1:0]     source_x,
	input  logic                 last_net,
	output logic                 done,
	output logic [1:0]           status,
	output logic [PAD_IDX_W-1:0] pad_index,
	output logic [BATCH_W-1:0]   assigned_total
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     pad_count_q;
	logic [BATCH_W-1:0]   batch_q;
	logic [SRC_W-1:0]     sx_q;
	logic [NET_W-1:0]     net_q;
	logic                 last_q;
	logic                 done_q;
	logic [1:0]           status_q;
	logic [PAD_IDX_W-1:0] pad_index_q;
	logic [BATCH_W-1:0]   total_q;

	logic                 accept;
	logic                 full;
	logic                 commit;
	logic                 bump;
	logic [BATCH_W-1:0]   batch_inc;
	cell_ctrl_t           ctrl;
	scan_tok_t            chain [MAX_PADS+1];
	scan_tok_t            tail;

	assign accept    = start && (state_q == S_IDLE);
	assign full      = (pad_count_q == CNT_W'(MAX_PADS));
	assign commit    = (state_q == S_SCAN) && (cnt_q == CNT_W'(MAX_PADS));
	assign tail      = chain[MAX_PADS];
	assign bump      = tail.found && (batch_q != BATCH_MAX);
	assign batch_inc = batch_q + BATCH_W'(bump);

	// Broadcast control to the cell row
	always_comb begin
		ctrl.wr        = accept && (op == OP_ADD) && !full;
		ctrl.mark      = commit && tail.found;
		ctrl.clr       = accept && (op == OP_CLEAR);
		ctrl.sel       = commit ? tail.idx : pad_count_q[PAD_IDX_W-1:0];
		ctrl.loc       = pad_location;
		ctrl.supply    = pad_is_supply;
		ctrl.owner     = net_q;
		ctrl.sx        = sx_q;
		ctrl.pad_count = pad_count_q;
	end

	// Row of pad cells, token enters empty at the head
	assign chain[0] = '0;

	for (genvar g = 0; g < MAX_PADS; g++) begin : g_cell
		nfpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (PAD_IDX_W'(g)),
			.ctrl     (ctrl),
			.tok_in   (chain[g]),
			.tok_out  (chain[g+1])
		);
	end

	// Sequencer, table counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pad_count_q <= '0;
			batch_q     <= '0;
			sx_q        <= '0;
			net_q       <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			pad_index_q <= '0;
			total_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q      <= 1'b1;
						status_q    <= ST_OK;
						pad_index_q <= '0;
						total_q     <= batch_q;
						case (op)
							OP_ADD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									pad_index_q <= pad_count_q[PAD_IDX_W-1:0];
									pad_count_q <= pad_count_q + CNT_W'(1);
								end
							end
							OP_ASSIGN: begin
								if (!has_source) begin
									status_q <= ST_SKIP;
									if (last_net) begin
										batch_q <= '0;
									end
								end else begin
									// hold the result until the token reaches the tail
									done_q  <= 1'b0;
									sx_q    <= source_x;
									net_q   <= net_id;
									last_q  <= last_net;
									cnt_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								pad_count_q <= '0;
								batch_q     <= '0;
								total_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (commit) begin
						done_q      <= 1'b1;
						status_q    <= tail.found ? ST_OK : ST_NOFREE;
						pad_index_q <= tail.found ? tail.idx : '0;
						total_q     <= batch_inc;
						batch_q     <= last_q ? '0 : batch_inc;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign pad_index      = pad_index_q;
	assign assigned_total = total_q;

endmodule

/* rtl/core/nfpa_checker.sv */
module nfpa_checker
	import nfpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 done,
	input  logic [1:0]           status,
	input  logic [PAD_IDX_W-1:0] pad_index
);

	// A result never coincides with a scan in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request either answers at once or starts a scan
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request produced neither result nor scan");

	// End of a scan always delivers its result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan finished without a result");

	// Failed requests report index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (pad_index == '0))
		else $error("non-zero pad index on a failed request");

endmodule

bind nearest_free_pad_allocator nfpa_checker u_nfpa_checker (.*);

/* tb/tb_nearest_free_pad_allocator.sv */
module tb_nearest_free_pad_allocator;
	import nfpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Op code the block treats as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEMS_TOTAL = 1600;
	localparam int N_PHASES    = 6;

	typedef struct packed {
		logic [1:0]              op;
		logic                    supply;
		logic signed [LOC_W-1:0] loc;
		logic [NET_W-1:0]        net;
		logic                    has_src;
		logic [SRC_W-1:0]        sx;
		logic                    last;
	} pad_req_t;

	typedef struct packed {
		status_t              status;
		logic [PAD_IDX_W-1:0] idx;
		logic [BATCH_W-1:0]   total;
	} alloc_res_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              op = OP_NOP;
	logic                    pad_is_supply = 1'b0;
	logic signed [LOC_W-1:0] pad_location = '0;
	logic [NET_W-1:0]        net_id = '0;
	logic                    has_source = 1'b0;
	logic [SRC_W-1:0]        source_x = '0;
	logic                    last_net = 1'b0;
	logic                    done;
	logic [1:0]              status;
	logic [PAD_IDX_W-1:0]    pad_index;
	logic [BATCH_W-1:0]      assigned_total;

	// Requests waiting to be driven and results still owed by the block
	pad_req_t   pad_req_q[$];
	alloc_res_t alloc_expect_q[$];
	pad_req_t   next_req;
	alloc_res_t exp_res;

	logic       req_taken = 1'b0;
	int         idle_pct = 0;
	int         items_queued = 0;
	int         err_cnt = 0;
	int         cycle_cnt = 0;

	// Shadow copy of the pad table
	logic signed [LOC_W-1:0] tbl_loc [MAX_PADS];
	logic                    tbl_supply [MAX_PADS];
	logic                    tbl_used [MAX_PADS];
	logic [NET_W-1:0]        tbl_owner [MAX_PADS];
	int                      tbl_count = 0;
	int                      batch_total = 0;

	nearest_free_pad_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.pad_is_supply  (pad_is_supply),
		.pad_location   (pad_location),
		.net_id         (net_id),
		.has_source     (has_source),
		.source_x       (source_x),
		.last_net       (last_net),
		.done           (done),
		.status         (status),
		.pad_index      (pad_index),
		.assigned_total (assigned_total)
	);

	initial forever #2 clk = ~clk;

	// Apply one request to the shadow table and return the result it should give
	function automatic alloc_res_t predict_allocation(pad_req_t r);
		alloc_res_t res;
		int         gap;
		int         near_gap;
		int         best_idx;
		bit         found;
		res.status = ST_OK;
		res.idx    = '0;
		res.total  = BATCH_W'(batch_total);
		case (r.op)
			OP_ADD: begin
				if (tbl_count >= MAX_PADS) begin
					res.status = ST_FULL;
				end else begin
					tbl_supply[tbl_count] = r.supply;
					tbl_loc[tbl_count]    = r.loc;
					tbl_used[tbl_count]   = 1'b0;
					res.idx = PAD_IDX_W'(tbl_count);
					tbl_count++;
				end
			end
			OP_ASSIGN: begin
				if (!r.has_src) begin
					res.status = ST_SKIP;
				end else begin
					found    = 1'b0;
					near_gap = 0;
					best_idx = 0;
					// strict less-than keeps the lowest index on a tie
					for (int i = 0; i < tbl_count; i++) begin
						if (!tbl_used[i] && !tbl_supply[i]) begin
							gap = int'(tbl_loc[i]) - int'(r.sx);
							if (gap < 0)
								gap = -gap;
							if (!found || gap < near_gap) begin
								found    = 1'b1;
								near_gap = gap;
								best_idx = i;
							end
						end
					end
					if (found) begin
						tbl_used[best_idx]  = 1'b1;
						tbl_owner[best_idx] = r.net;
						if (batch_total < int'(BATCH_MAX))
							batch_total++;
						res.idx = PAD_IDX_W'(best_idx);
					end else begin
						res.status = ST_NOFREE;
					end
				end
				res.total = BATCH_W'(batch_total);
				if (r.last)
					batch_total = 0;
			end
			OP_CLEAR: begin
				for (int i = 0; i < MAX_PADS; i++)
					tbl_used[i] = 1'b0;
				tbl_count   = 0;
				batch_total = 0;
				res.total   = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic queue_req(logic [1:0] o, logic sup, logic signed [LOC_W-1:0] loc,
		logic [NET_W-1:0] net, logic hs, logic [SRC_W-1:0] sx, logic last);
		pad_req_t r;
		r.op      = o;
		r.supply  = sup;
		r.loc     = loc;
		r.net     = net;
		r.has_src = hs;
		r.sx      = sx;
		r.last    = last;
		pad_req_q.push_back(r);
		items_queued++;
	endtask

	// Locations lean on a coarse grid so that equal distances turn up often
	function automatic logic signed [LOC_W-1:0] pick_location();
		int r;
		r = $urandom_range(99, 0);
		if (r < 5)
			return '1;
		if (r < 15)
			return LOC_W'(1023);
		if (r < 20)
			return '0;
		if (r < 50)
			return LOC_W'($urandom_range(15, 0) * 64);
		return LOC_W'($urandom_range(1023, 0));
	endfunction

	// Half-grid steps hit the midpoints between grid pads
	function automatic logic [SRC_W-1:0] pick_source();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return '0;
		if (r < 20)
			return SRC_W'(1023);
		if (r < 55)
			return SRC_W'($urandom_range(31, 0) * 32);
		return SRC_W'($urandom_range(1023, 0));
	endfunction

	task automatic add_pad();
		queue_req(OP_ADD, ($urandom_range(99, 0) < 20), pick_location(),
			NET_W'($urandom), 1'($urandom), SRC_W'($urandom), 1'($urandom));
	endtask

	task automatic assign_net(logic last);
		queue_req(OP_ASSIGN, 1'($urandom), LOC_W'($urandom), NET_W'($urandom),
			($urandom_range(99, 0) < 90), pick_source(), last);
	endtask

	// Well-formed batches with random content, the odd table fill and some noise
	task automatic gen_random(int goal);
		int kind;
		int n_pads;
		int n_nets;
		kind   = 0;
		n_pads = 0;
		n_nets = 0;
		while (items_queued < goal) begin
			kind = $urandom_range(99, 0);
			if (kind < 70) begin
				if ($urandom_range(2, 0) == 0)
					queue_req(OP_CLEAR, 1'($urandom), LOC_W'($urandom), NET_W'($urandom),
						1'($urandom), SRC_W'($urandom), 1'($urandom));
				n_pads = ($urandom_range(7, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
				repeat (n_pads) add_pad();
				n_nets = $urandom_range(n_pads + 2, 1);
				for (int i = 0; i < n_nets; i++)
					assign_net(i == n_nets - 1);
			end else if (kind < 78) begin
				// run the table up to full and past it
				queue_req(OP_CLEAR, 1'b0, '0, '0, 1'b0, '0, 1'b0);
				repeat (MAX_PADS + $urandom_range(3, 1)) add_pad();
				repeat ($urandom_range(4, 1)) assign_net(1'($urandom_range(1, 0)));
			end else begin
				repeat ($urandom_range(5, 1))
					queue_req(2'($urandom_range(3, 0)), 1'($urandom),
						LOC_W'(int'($urandom_range(1024, 0)) - 1), NET_W'($urandom),
						1'($urandom), SRC_W'($urandom), 1'($urandom));
			end
		end
	endtask

	// Edge cases: empty table, no-op, ties, supply pads, unplaced pad, skip, batch end
	task automatic gen_directed();
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0000, 1'b1, '0, 1'b0);
		queue_req(OP_NOP, 1'b1, '1, 16'hffff, 1'b1, '1, 1'b1);
		queue_req(OP_ADD, 1'b0, '1, '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b1, LOC_W'(0), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(1023), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(500), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(520), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b1, LOC_W'(510), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'hffff, 1'b1, SRC_W'(510), 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h1234, 1'b1, SRC_W'(510), 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0001, 1'b0, SRC_W'(1023), 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0002, 1'b1, SRC_W'(0), 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h8000, 1'b1, SRC_W'(1023), 1'b1);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0003, 1'b1, SRC_W'(600), 1'b0);
		queue_req(OP_NOP, 1'b0, '0, '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(1023), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(1023), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0004, 1'b1, SRC_W'(1000), 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0005, 1'b0, '0, 1'b1);
		queue_req(OP_CLEAR, 1'b1, '1, 16'hffff, 1'b1, '1, 1'b1);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'h0006, 1'b1, SRC_W'(5), 1'b0);
		queue_req(OP_ADD, 1'b0, LOC_W'(0), '0, 1'b0, '0, 1'b0);
		queue_req(OP_ASSIGN, 1'b0, '0, 16'ha5a5, 1'b1, SRC_W'(1023), 1'b1);
	endtask

	// Stimulus, sender idling phases and end of run
	initial begin : stimulus
		int phase_pct [N_PHASES];
		phase_pct = '{0, 62, 26, 0, 62, 26};
		for (int i = 0; i < MAX_PADS; i++) begin
			tbl_loc[i]    = '0;
			tbl_supply[i] = 1'b0;
			tbl_used[i]   = 1'b0;
			tbl_owner[i]  = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			idle_pct = phase_pct[p];
			if (p == 0)
				gen_directed();
			gen_random((p + 1) * ITEMS_TOTAL / N_PHASES);
			while (pad_req_q.size() != 0 || start)
				@(posedge clk);
		end
		while (alloc_expect_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS nearest_free_pad_allocator");
		else
			$display("FAIL nearest_free_pad_allocator");
		$finish;
	end

	// Request driver: holds start until the request is taken, idles at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || req_taken) begin
				if (pad_req_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					next_req = pad_req_q.pop_front();
					start         <= 1'b1;
					op            <= next_req.op;
					pad_is_supply <= next_req.supply;
					pad_location  <= next_req.loc;
					net_id        <= next_req.net;
					has_source    <= next_req.has_src;
					source_x      <= next_req.sx;
					last_net      <= next_req.last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check the strobe first, then predict any request taken now
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (alloc_expect_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result status %0d pad_index %0d assigned_total %0d",
						$realtime, status, pad_index, assigned_total);
				end else begin
					exp_res = alloc_expect_q.pop_front();
					if (status !== exp_res.status) begin
						err_cnt++;
						$display("%0t: status expected %0d actual %0d",
							$realtime, exp_res.status, status);
					end
					if (pad_index !== exp_res.idx) begin
						err_cnt++;
						$display("%0t: pad_index expected %0d actual %0d",
							$realtime, exp_res.idx, pad_index);
					end
					if (assigned_total !== exp_res.total) begin
						err_cnt++;
						$display("%0t: assigned_total expected %0d actual %0d",
							$realtime, exp_res.total, assigned_total);
					end
				end
			end
			if (start && !busy)
				alloc_expect_q.push_back(predict_allocation({op, pad_is_supply, pad_location,
					net_id, has_source, source_x, last_net}));
			req_taken <= start && !busy;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL nearest_free_pad_allocator");
			$finish;
		end
	end

endmodule
